// File: rtl/mps_pkg.sv
// ----------------------------------------------------------------------------
// mps_pkg
// Types, fixed-point constants and the CORDIC angle table of the path smoother.
// ----------------------------------------------------------------------------
`default_nettype none

package mps_pkg;

  // one motion estimate request
  typedef struct packed {
    logic signed [31:0] shift_x;
    logic signed [31:0] shift_y;
    logic signed [31:0] turn;
    logic signed [31:0] scale_step;
  } in_item_t;

  // one correction request
  typedef struct packed {
    logic signed [31:0] corr_x;
    logic signed [31:0] corr_y;
    logic signed [31:0] corr_angle;
    logic signed [31:0] corr_zoom;
  } out_item_t;

  // sequencer states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_PHASE,
    ST_ANGLE,
    ST_CINIT,
    ST_CORDIC,
    ST_QUAD,
    ST_M1,
    ST_M2,
    ST_M3,
    ST_M4,
    ST_M5,
    ST_M6,
    ST_STORE,
    ST_RDC,
    ST_RD0,
    ST_DIV,
    ST_EMIT
  } state_t;

  localparam int CORDIC_STEPS = 16;
  localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam logic signed [33:0] TURN_PER_RAD_Q32 = 34'sd683565276;
  localparam logic signed [33:0] TWO_PI_Q16 = 34'sd411775;

  // atan(2^-i) in Q16.16
  function automatic logic [15:0] atan_q16(input logic [3:0] i);
    logic [15:0] v;
    case (i)
      4'd0:    v = 16'd51472;
      4'd1:    v = 16'd30386;
      4'd2:    v = 16'd16055;
      4'd3:    v = 16'd8150;
      4'd4:    v = 16'd4091;
      4'd5:    v = 16'd2047;
      4'd6:    v = 16'd1024;
      4'd7:    v = 16'd512;
      4'd8:    v = 16'd256;
      4'd9:    v = 16'd128;
      4'd10:   v = 16'd64;
      4'd11:   v = 16'd32;
      4'd12:   v = 16'd16;
      4'd13:   v = 16'd8;
      4'd14:   v = 16'd4;
      default: v = 16'd2;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// File: rtl/mps_if.sv
// ----------------------------------------------------------------------------
// mps_in_if / mps_out_if
// Valid/ready channels carrying motion estimates and corrections.
// ----------------------------------------------------------------------------
`default_nettype none

interface mps_in_if;
  logic             valid;
  logic             ready;
  mps_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mps_out_if;
  logic              valid;
  logic              ready;
  mps_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/motion_path_smoother.sv
// ----------------------------------------------------------------------------
// motion_path_smoother
// Integrates per-frame motion into an absolute pose and emits the centre pose
// of a sliding window minus the window mean.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                   | when
//  motion   | in  | shift_x, shift_y, turn, scale_step        | one per frame
//  corr     | out | corr_x, corr_y, corr_angle, corr_zoom     | once window full
//
//  A request keeps the sequencer busy through the 16-step CORDIC loop, the
//  single shared multiplier and, when a result is due, the reciprocal mean
//  stage. motion.ready is high only while idle, so requests wait meanwhile.
//  A finished correction waits in the output register; the next request is
//  taken meanwhile, and the sequencer holds before emitting if it is still full.
//  rst is synchronous and clears the sequencer, accumulators, sums and counts.
// ----------------------------------------------------------------------------
`default_nettype none

module motion_path_smoother #(
  parameter int WINDOW = 30,
  parameter int HALF   = 15
) (
  input  wire logic   clk,
  input  wire logic   rst,
  mps_in_if.sink      motion,
  mps_out_if.source   corr
);

  localparam int CENTER = (HALF < WINDOW) ? HALF : (WINDOW - 1);
  localparam int IW     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int FW     = $clog2(WINDOW + 1);
  localparam int SW     = 33 + $clog2(WINDOW);
  localparam int SATW   = (SW + 1 > 40) ? SW + 1 : 40;
  // mean stage: magnitude = hi * 2^16 + lo, hi and each partial below 2^HW
  localparam int HW     = 16 + IW;
  localparam int DIV_K  = 16 + 2 * IW;
  localparam logic signed [33:0] DIV_M =
    34'(((64'd1 << DIV_K) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));
  localparam logic [3:0] DIV_LAST = 4'd10;

  typedef logic signed [3:0][31:0] pose_t;

  // saturate to signed 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [SATW-1:0] v);
    logic signed [31:0] r;
    if (v > SATW'(32'sh7FFFFFFF)) r = 32'sh7FFFFFFF;
    else if (v < -(SATW'(33'sh080000000))) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  mps_pkg::state_t state, state_next;

  // latched request
  logic signed [31:0] dx, dy, da, dz;
  // accumulators
  logic signed [31:0] pos_x, pos_y, heading, zoom_total;
  // shared multiplier
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] prod;
  logic signed [68:0] acc;
  // cordic
  logic signed [35:0] z;
  logic signed [33:0] cx, cy, cos_v, sin_v;
  logic [3:0] step;
  logic [1:0] quad;
  // window
  pose_t mem [WINDOW];
  pose_t rd_data, cen;
  logic [IW-1:0] rd_addr, head, cphys, wphys;
  logic [FW-1:0] fill, zeros_left;
  logic signed [SW-1:0] sum [4];
  // mean by reciprocal multiplication on the shared multiplier
  logic [SW-2:0] dvd [4];
  logic [HW-1:0] qhi [4];
  logic [15:0]   qlo [4];
  logic [HW-1:0] tpart [4];
  logic [IW-1:0] rem_part [4];
  logic [SW-2:0] quo [4];
  logic [3:0] neg;
  logic [3:0] div_cnt;
  // output register
  logic out_valid;
  mps_pkg::out_item_t out_data;

  logic out_free;
  logic signed [38:0] n_round;
  logic [IW:0] cwide, wwide;

  assign out_free = !out_valid || corr.ready;
  assign n_round  = 39'((acc + 69'sd536870912) >>> 30);
  assign cwide    = (IW + 1)'(head) + (IW + 1)'(CENTER);
  assign cphys    = (cwide >= (IW + 1)'(WINDOW)) ? IW'(cwide - (IW + 1)'(WINDOW)) : IW'(cwide);
  assign wwide    = (IW + 1)'(head) + (IW + 1)'(fill);
  assign wphys    = (wwide >= (IW + 1)'(WINDOW)) ? IW'(wwide - (IW + 1)'(WINDOW)) : IW'(wwide);

  // remainders of the high parts and the assembled quotients
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      rem_part[k] = IW'(dvd[k][SW-2:16] - qhi[k] * HW'(WINDOW));
      quo[k]      = {qhi[k], qlo[k]};
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      mps_pkg::ST_IDLE:   if (motion.valid) state_next = mps_pkg::ST_PHASE;
      mps_pkg::ST_PHASE:  state_next = mps_pkg::ST_ANGLE;
      mps_pkg::ST_ANGLE:  state_next = mps_pkg::ST_CINIT;
      mps_pkg::ST_CINIT:  state_next = mps_pkg::ST_CORDIC;
      mps_pkg::ST_CORDIC: if (step == 4'(mps_pkg::CORDIC_STEPS - 1)) state_next = mps_pkg::ST_QUAD;
      mps_pkg::ST_QUAD:   state_next = mps_pkg::ST_M1;
      mps_pkg::ST_M1:     state_next = mps_pkg::ST_M2;
      mps_pkg::ST_M2:     state_next = mps_pkg::ST_M3;
      mps_pkg::ST_M3:     state_next = mps_pkg::ST_M4;
      mps_pkg::ST_M4:     state_next = mps_pkg::ST_M5;
      mps_pkg::ST_M5:     state_next = mps_pkg::ST_M6;
      mps_pkg::ST_M6:     state_next = mps_pkg::ST_STORE;
      mps_pkg::ST_STORE: begin
        if (fill + FW'(1) < FW'(WINDOW)) state_next = mps_pkg::ST_IDLE;
        else state_next = mps_pkg::ST_RDC;
      end
      mps_pkg::ST_RDC:    state_next = mps_pkg::ST_RD0;
      mps_pkg::ST_RD0:    state_next = mps_pkg::ST_DIV;
      mps_pkg::ST_DIV:    if (div_cnt == DIV_LAST) state_next = mps_pkg::ST_EMIT;
      mps_pkg::ST_EMIT:   if (out_free) state_next = mps_pkg::ST_IDLE;
      default:            state_next = mps_pkg::ST_IDLE;
    endcase
  end

  // multiplier operands and read address
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    rd_addr = head;
    case (state)
      mps_pkg::ST_PHASE: begin
        mul_a = 34'(heading);
        mul_b = mps_pkg::TURN_PER_RAD_Q32;
      end
      mps_pkg::ST_ANGLE: begin
        mul_a = {4'b0, prod[45:16]};
        mul_b = mps_pkg::TWO_PI_Q16;
      end
      mps_pkg::ST_M1: begin
        mul_a = 34'(dx);
        mul_b = cos_v;
      end
      mps_pkg::ST_M2: begin
        mul_a = 34'(dy);
        mul_b = sin_v;
      end
      mps_pkg::ST_M3: begin
        mul_a = 34'(dx);
        mul_b = sin_v;
      end
      mps_pkg::ST_M4: begin
        mul_a = 34'(dy);
        mul_b = cos_v;
      end
      mps_pkg::ST_RDC: rd_addr = cphys;
      mps_pkg::ST_DIV: begin
        // high parts first, then remainder-and-low partials
        if (div_cnt inside {[4'd0:4'd3]}) begin
          mul_a = 34'(dvd[div_cnt[1:0]][SW-2:16]);
          mul_b = DIV_M;
        end else if (div_cnt inside {[4'd6:4'd9]}) begin
          mul_a = 34'(tpart[2'(div_cnt - 4'd6)]);
          mul_b = DIV_M;
        end
      end
      default: ;
    endcase
  end

  assign motion.ready = (state == mps_pkg::ST_IDLE);
  assign corr.valid   = out_valid;
  assign corr.data    = out_data;

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= mps_pkg::ST_IDLE;
      pos_x      <= '0;
      pos_y      <= '0;
      heading    <= '0;
      zoom_total <= '0;
      head       <= '0;
      fill       <= FW'(CENTER);
      zeros_left <= FW'(CENTER);
      out_valid  <= 1'b0;
      for (int k = 0; k < 4; k++) sum[k] <= '0;
    end else begin
      state <= state_next;
      if (state == mps_pkg::ST_EMIT && out_free) out_valid <= 1'b1;
      else if (corr.ready) out_valid <= 1'b0;
      case (state)
        mps_pkg::ST_QUAD: begin
          heading    <= sat32(SATW'(heading) + SATW'(da));
          zoom_total <= sat32(SATW'(zoom_total) + SATW'(dz));
        end
        mps_pkg::ST_M4: pos_x <= sat32(SATW'(pos_x) + SATW'(n_round));
        mps_pkg::ST_M6: pos_y <= sat32(SATW'(pos_y) + SATW'(n_round));
        mps_pkg::ST_STORE: begin
          fill   <= fill + FW'(1);
          sum[0] <= sum[0] + SW'(pos_x);
          sum[1] <= sum[1] + SW'(pos_y);
          sum[2] <= sum[2] + SW'(heading);
          sum[3] <= sum[3] + SW'(zoom_total);
        end
        mps_pkg::ST_EMIT: begin
          if (out_free) begin
            fill      <= fill - FW'(1);
            head      <= (head == IW'(WINDOW - 1)) ? '0 : head + IW'(1);
            if (zeros_left != '0) begin
              zeros_left <= zeros_left - FW'(1);
            end else begin
              for (int k = 0; k < 4; k++) sum[k] <= sum[k] - SW'($signed(rd_data[k]));
            end
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (state)
      mps_pkg::ST_IDLE: begin
        dx <= motion.data.shift_x;
        dy <= motion.data.shift_y;
        da <= motion.data.turn;
        dz <= motion.data.scale_step;
      end
      mps_pkg::ST_ANGLE: quad <= prod[47:46];
      mps_pkg::ST_CINIT: begin
        z    <= prod[51:16];
        cx   <= mps_pkg::CORDIC_GAIN_Q30;
        cy   <= '0;
        step <= '0;
      end
      mps_pkg::ST_CORDIC: begin
        step <= step + 4'd1;
        if (z >= 0) begin
          cx <= cx - (cy >>> step);
          cy <= cy + (cx >>> step);
          z  <= z - 36'(mps_pkg::atan_q16(step));
        end else begin
          cx <= cx + (cy >>> step);
          cy <= cy - (cx >>> step);
          z  <= z + 36'(mps_pkg::atan_q16(step));
        end
      end
      mps_pkg::ST_QUAD: begin
        case (quad)
          2'd0: begin cos_v <= cx;  sin_v <= cy;  end
          2'd1: begin cos_v <= -cy; sin_v <= cx;  end
          2'd2: begin cos_v <= -cx; sin_v <= -cy; end
          default: begin cos_v <= cy; sin_v <= -cx; end
        endcase
      end
      mps_pkg::ST_M2: acc <= 69'(prod);
      mps_pkg::ST_M3: acc <= acc - 69'(prod);
      mps_pkg::ST_M4: acc <= 69'(prod);
      mps_pkg::ST_M5: acc <= acc + 69'(prod);
      mps_pkg::ST_RD0: begin
        cen     <= rd_data;
        div_cnt <= '0;
        for (int k = 0; k < 4; k++) begin
          neg[k] <= sum[k][SW-1];
          dvd[k] <= sum[k][SW-1] ? (SW-1)'(-sum[k]) : (SW-1)'(sum[k]);
        end
      end
      mps_pkg::ST_DIV: begin
        div_cnt <= div_cnt + 4'd1;
        // products are registered, so each arrives in the cycle after its operands
        if (div_cnt inside {[4'd1:4'd4]}) qhi[2'(div_cnt - 4'd1)] <= prod[DIV_K +: HW];
        if (div_cnt == 4'd5) begin
          for (int k = 0; k < 4; k++) tpart[k] <= {rem_part[k], dvd[k][15:0]};
        end
        if (div_cnt inside {[4'd7:4'd10]}) qlo[2'(div_cnt - 4'd7)] <= prod[DIV_K +: 16];
      end
      mps_pkg::ST_EMIT: begin
        if (out_free) begin
          out_data.corr_x     <= sat32(SATW'($signed(cen[0])) -
                                 (neg[0] ? -SATW'(quo[0]) : SATW'(quo[0])));
          out_data.corr_y     <= sat32(SATW'($signed(cen[1])) -
                                 (neg[1] ? -SATW'(quo[1]) : SATW'(quo[1])));
          out_data.corr_angle <= sat32(SATW'($signed(cen[2])) -
                                 (neg[2] ? -SATW'(quo[2]) : SATW'(quo[2])));
          out_data.corr_zoom  <= sat32(SATW'($signed(cen[3])) -
                                 (neg[3] ? -SATW'(quo[3]) : SATW'(quo[3])));
        end
      end
      default: ;
    endcase
  end

  // pose window ring
  always_ff @(posedge clk) begin
    if (state == mps_pkg::ST_STORE) mem[wphys] <= {zoom_total, heading, pos_y, pos_x};
    rd_data <= mem[rd_addr];
  end

  // checks
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill >= FW'(CENTER) && fill <= FW'(WINDOW))
    else $error("window fill out of range");

  a_zeros_bound: assert property (@(posedge clk) disable iff (rst)
    zeros_left <= FW'(CENTER))
    else $error("initial zero count grew");

  a_emit_full: assert property (@(posedge clk) disable iff (rst)
    (state == mps_pkg::ST_EMIT && out_free) |-> fill == FW'(WINDOW))
    else $error("correction emitted without a full window");

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    (motion.valid && motion.ready) |=> state == mps_pkg::ST_PHASE)
    else $error("request taken outside idle");

endmodule

`default_nettype wire

// File: bench/motion_path_smoother_tb.sv
// ----------------------------------------------------------------------------
// motion_path_smoother_tb
// Drives motion estimates with random idling and back-pressure, predicts each
// correction with an independent fixed-point model and checks field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module motion_path_smoother_tb;

  localparam int WIN = 30;
  localparam int CTR = 15;
  localparam int N_RANDOM = 650;
  localparam longint LIMIT = 1_500_000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mps_in_if  motion ();
  mps_out_if corr ();

  motion_path_smoother DUT (.clk(clk), .rst(rst), .motion(motion), .corr(corr));

  always #6 clk = ~clk;

  // predictor state
  logic signed [31:0] px, py, hd, zt;
  logic signed [31:0] wx[WIN], wy[WIN], wa[WIN], wz[WIN];
  logic signed [63:0] sx, sy, sa, sz;
  int fill;

  mps_pkg::in_item_t  pending_q[$];
  mps_pkg::out_item_t corrections_q[$];
  int  errors = 0;
  bit  stim_done = 1'b0;
  bit  calm = 1'b0;
  bit  hold_sender = 1'b0;
  int  long_hold = 0;
  longint cycles = 0;
  int  src_gap = 0, snk_gap = 0;

  function automatic logic signed [31:0] clip32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic [15:0] arctan_step(input int i);
    logic [15:0] t[16];
    t = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
          256, 128, 64, 32, 16, 8, 4, 2};
    return t[i];
  endfunction

  // sine and cosine of a Q16.16 heading, both Q30
  task automatic heading_trig(input logic signed [31:0] ang,
                              output logic signed [63:0] s,
                              output logic signed [63:0] c);
    logic signed [63:0] prod, z, x, y, nx;
    logic [31:0] ph;
    logic [63:0] rest;
    prod = 64'(ang) * 64'sd683565276;
    ph = prod[47:16];
    rest = {34'd0, ph[29:0]} * 64'd411775;
    z = $signed(rest >> 16);
    x = 64'sd652032874;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - arctan_step(i);
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + arctan_step(i);
      end
      x = nx;
    end
    case (ph[31:30])
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endtask

  task automatic smoother_reset();
    px = 0; py = 0; hd = 0; zt = 0;
    for (int k = 0; k < WIN; k++) begin
      wx[k] = 0; wy[k] = 0; wa[k] = 0; wz[k] = 0;
    end
    sx = 0; sy = 0; sa = 0; sz = 0;
    fill = CTR;
  endtask

  // advance the trajectory by one frame and queue any correction
  task automatic integrate_frame(input mps_pkg::in_item_t m);
    logic signed [63:0] s, c;
    logic signed [127:0] ax, ay;
    mps_pkg::out_item_t r;
    heading_trig(hd, s, c);
    hd = clip32(64'(hd) + 64'(m.turn));
    ax = 128'(m.shift_x) * 128'(c) - 128'(m.shift_y) * 128'(s) + (128'sd1 <<< 29);
    ay = 128'(m.shift_x) * 128'(s) + 128'(m.shift_y) * 128'(c) + (128'sd1 <<< 29);
    px = clip32(64'(px) + 64'(ax >>> 30));
    py = clip32(64'(py) + 64'(ay >>> 30));
    zt = clip32(64'(zt) + 64'(m.scale_step));
    if (fill < WIN) begin
      wx[fill] = px; wy[fill] = py; wa[fill] = hd; wz[fill] = zt;
      fill++;
      sx += px; sy += py; sa += hd; sz += zt;
    end
    if (fill < WIN) return;
    r.corr_x     = clip32(64'(wx[CTR]) - sx / WIN);
    r.corr_y     = clip32(64'(wy[CTR]) - sy / WIN);
    r.corr_angle = clip32(64'(wa[CTR]) - sa / WIN);
    r.corr_zoom  = clip32(64'(wz[CTR]) - sz / WIN);
    corrections_q.push_back(r);
    sx -= wx[0]; sy -= wy[0]; sa -= wa[0]; sz -= wz[0];
    for (int k = 0; k + 1 < WIN; k++) begin
      wx[k] = wx[k+1]; wy[k] = wy[k+1]; wa[k] = wa[k+1]; wz[k] = wz[k+1];
    end
    wx[WIN-1] = 0; wy[WIN-1] = 0; wa[WIN-1] = 0; wz[WIN-1] = 0;
    fill--;
  endtask

  function automatic logic [31:0] rand_field();
    case ($urandom_range(0, 9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 3) << 16;
      3, 4: return $signed($urandom_range(0, 20 << 16)) - (10 << 16);
      5, 6: return $signed($urandom_range(0, 1 << 16)) - (1 << 15);
      default: return $urandom;
    endcase
  endfunction

  function automatic mps_pkg::in_item_t mk(input logic [31:0] a, b, c, d);
    mps_pkg::in_item_t m;
    m.shift_x = a; m.shift_y = b; m.turn = c; m.scale_step = d;
    return m;
  endfunction

  // request driver
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst) begin
      motion.valid <= 1'b0;
      motion.data <= '0;
    end else begin
      if (motion.valid && motion.ready) begin
        integrate_frame(motion.data);
        void'(pending_q.pop_front());
      end
      if (src_gap > 0) begin
        src_gap <= src_gap - 1;
        motion.valid <= 1'b0;
      end else if (hold_sender || pending_q.size() == 0 ||
                   (motion.valid && motion.ready && pending_q.size() == 0)) begin
        motion.valid <= 1'b0;
      end else if (!calm && !(motion.valid && !motion.ready) && $urandom_range(0, 9) == 0)
      begin
        src_gap <= $urandom_range(1, 18);
        motion.valid <= 1'b0;
      end else begin
        motion.valid <= 1'b1;
        motion.data <= pending_q[0];
      end
    end
  end

  // correction monitor with its own back-pressure
  always @(posedge clk) begin
    if (rst) begin
      corr.ready <= 1'b0;
    end else begin
      if (corr.valid && corr.ready) begin
        if (corrections_q.size() == 0) begin
          $display("%0t unexpected correction %h", $time, corr.data);
          errors++;
        end else begin
          if (corr.data.corr_x !== corrections_q[0].corr_x)
            $display("%0t corr_x exp %0d got %0d", $time,
                     corrections_q[0].corr_x, corr.data.corr_x);
          if (corr.data.corr_y !== corrections_q[0].corr_y)
            $display("%0t corr_y exp %0d got %0d", $time,
                     corrections_q[0].corr_y, corr.data.corr_y);
          if (corr.data.corr_angle !== corrections_q[0].corr_angle)
            $display("%0t corr_angle exp %0d got %0d", $time,
                     corrections_q[0].corr_angle, corr.data.corr_angle);
          if (corr.data.corr_zoom !== corrections_q[0].corr_zoom)
            $display("%0t corr_zoom exp %0d got %0d", $time,
                     corrections_q[0].corr_zoom, corr.data.corr_zoom);
          if (corr.data !== corrections_q[0]) errors++;
          void'(corrections_q.pop_front());
        end
      end
      if (long_hold > 0) begin
        long_hold <= long_hold - 1;
        corr.ready <= 1'b0;
      end else if (snk_gap > 0) begin
        snk_gap <= snk_gap - 1;
        corr.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        snk_gap <= $urandom_range(1, 18);
        corr.ready <= 1'b0;
      end else begin
        corr.ready <= 1'b1;
      end
    end
  end

  // timeout
  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    motion.valid = 1'b0;
    motion.data = '0;
    corr.ready = 1'b0;
    smoother_reset();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, zero, quarter turns, saturation
    pending_q.push_back(mk(0, 0, 0, 0));
    pending_q.push_back(mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
    pending_q.push_back(mk(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff));
    pending_q.push_back(mk(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000));
    pending_q.push_back(mk(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h80000000));
    pending_q.push_back(mk(32'hffffffff, 32'h00000001, 32'd102944, 32'hffffffff));
    for (int i = 0; i < 18; i++)
      pending_q.push_back(mk(32'd65536 * (i + 1), -32'sd65536 * i, 32'd25736 * i,
                             32'd655 * i));
    // fill, then starve the receiver so the block stalls its input
    for (int i = 0; i < 20; i++) pending_q.push_back(mk(rand_field(), rand_field(),
                                                         rand_field(), rand_field()));
    wait (pending_q.size() < 18);
    @(posedge clk);
    long_hold <= 400;
    wait (pending_q.size() == 0);
    // sender pauses until every correction has drained
    hold_sender <= 1'b1;
    wait (corrections_q.size() == 0);
    @(posedge clk);
    hold_sender <= 1'b0;

    // random frames
    for (int i = 0; i < N_RANDOM; i++) begin
      pending_q.push_back(mk(rand_field(), rand_field(), rand_field(), rand_field()));
      if (i == N_RANDOM - 120) begin
        wait (pending_q.size() == 0);
        calm <= 1'b1;
      end
    end
    wait (pending_q.size() == 0 && !motion.valid);
    wait (corrections_q.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0 && corrections_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
